// File: hdl/lpht_pkg.sv
package lpht_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int KIND_W    = 2;
    localparam int KEY_W     = 31;
    localparam int VAL_W     = 32;
    localparam int STAT_W    = 3;
    localparam int IDX_W     = 4;
    // slot word: used flag, key, value
    localparam int WORD_W    = 1 + KEY_W + VAL_W;

    typedef enum logic [KIND_W-1:0] {
        K_CLEAR  = 2'd0,
        K_INSERT = 2'd1,
        K_LOOKUP = 2'd2,
        K_UPDATE = 2'd3
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE    = 3'd0,
        ST_COLLIDE = 3'd1,
        ST_FOUND   = 3'd2,
        ST_MISSING = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_WIPE,
        S_HASH,
        S_SCAN,
        S_REPLY
    } t_state;

    typedef struct packed {
        logic take_in;
        logic wipe_start;
        logic hash_start;
        logic scan_start;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic wipe_done;
        logic hash_done;
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

// File: hdl/lpht_ram.sv
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/lpht_mod.sv
// Key modulo SLOTS by reciprocal multiplication. The quotient estimate
// (key * floor(2^KEY_W / SLOTS)) >> KEY_W is never high and at most one short,
// so the remainder lands below 2 * SLOTS and one compare and subtract settles it.
// o_done pulses once r_rem is loaded; o_rem then holds until the next start.
module lpht_mod import lpht_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [KEY_W-1:0]         i_key,
    output logic                     o_done,
    output logic [$clog2(SLOTS)-1:0] o_rem
);

    localparam int AW = $clog2(SLOTS);
    localparam logic [KEY_W-1:0] RECIP = KEY_W'((64'd1 << KEY_W) / 64'(SLOTS));

    logic               r_key_vld;
    logic               r_q_vld;
    logic               r_done;
    logic [KEY_W-1:0]   r_key;
    logic [AW:0]        r_q;
    logic [AW-1:0]      r_rem;

    logic [2*KEY_W-1:0] w_prod;
    logic [AW:0]        w_qn;
    logic [AW:0]        w_diff;
    logic [AW:0]        w_sub;
    logic [AW-1:0]      n_rem;

    // only the low AW+1 bits of quotient and remainder matter: the true
    // remainder of the estimate is below 2 * SLOTS
    always_comb begin
        w_prod = {{KEY_W{1'b0}}, r_key} * {{KEY_W{1'b0}}, RECIP};
        w_qn   = r_q * (AW+1)'(SLOTS);
        w_diff = r_key[AW:0] - w_qn;
        w_sub  = w_diff - (AW+1)'(SLOTS);
        if (w_diff >= (AW+1)'(SLOTS)) begin
            n_rem = w_sub[AW-1:0];
        end else begin
            n_rem = w_diff[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_vld <= 1'b0;
            r_q_vld   <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_key_vld <= i_start;
            r_q_vld   <= r_key_vld;
            r_done    <= r_q_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key <= i_key;
        end
        if (r_key_vld) begin
            r_q <= w_prod[KEY_W+AW:KEY_W];
        end
        if (r_q_vld) begin
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// File: hdl/lpht_dp.sv
module lpht_dp import lpht_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [KEY_W-1:0]  i_rec_key,
    input  logic [VAL_W-1:0]  i_new_value,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [STAT_W-1:0] o_status,
    output logic [IDX_W-1:0]  o_slot_index,
    output logic [VAL_W-1:0]  o_found_value
);

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    // latched word
    t_kind             r_kind;
    logic [KEY_W-1:0]  r_key;
    logic [VAL_W-1:0]  r_val;

    // sweep / probe pointers
    logic              r_wipe;
    logic              r_scan;
    logic [AW-1:0]     r_ptr;
    logic [CW-1:0]     r_cnt;
    logic [AW-1:0]     r_chk;
    logic              r_chk_vld;

    // result and output registers
    t_status           r_res_st;
    logic [IDX_W-1:0]  r_res_idx;
    logic [VAL_W-1:0]  r_res_fv;
    logic              r_out_vld;
    t_status           r_out_st;
    logic [IDX_W-1:0]  r_out_idx;
    logic [VAL_W-1:0]  r_out_fv;

    logic              w_hash_done;
    logic [AW-1:0]     w_home;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [WORD_W-1:0] w_wdata;
    logic [WORD_W-1:0] w_rdata;
    logic              w_rd_used;
    logic [KEY_W-1:0]  w_rd_key;
    logic [VAL_W-1:0]  w_rd_val;

    logic              w_insert;
    logic              w_hit;
    logic              w_miss;
    logic              w_finish;
    logic              w_issue;
    logic              w_wipe_last;
    logic [AW-1:0]     n_ptr;
    logic [AW+IDX_W-1:0] w_idx_ext;

    lpht_mod #(.SLOTS(SLOTS)) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.hash_start),
        .i_key   (i_rec_key),
        .o_done  (w_hash_done),
        .o_rem   (w_home)
    );

    lpht_ram #(.WIDTH(WORD_W), .DEPTH(SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_ptr),
        .o_rdata (w_rdata)
    );

    assign w_rd_used = w_rdata[WORD_W-1];
    assign w_rd_key  = w_rdata[KEY_W+VAL_W-1:VAL_W];
    assign w_rd_val  = w_rdata[VAL_W-1:0];

    assign w_insert  = (r_kind == K_INSERT);

    always_comb begin
        if (w_insert) begin
            w_hit = r_scan && r_chk_vld && !w_rd_used;
        end else begin
            w_hit = r_scan && r_chk_vld && w_rd_used && (w_rd_key == r_key);
        end
    end

    // last slot checked with no match
    assign w_miss      = r_scan && r_chk_vld && !w_hit && (r_cnt == CW'(SLOTS));
    assign w_finish    = w_hit || w_miss;
    assign w_issue     = r_scan && !w_finish && (r_cnt != CW'(SLOTS));
    assign w_wipe_last = r_wipe && (r_ptr == AW'(SLOTS-1));
    assign n_ptr       = (r_ptr == AW'(SLOTS-1)) ? '0 : r_ptr + 1'b1;
    assign w_idx_ext   = {{IDX_W{1'b0}}, r_chk};

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_chk;
        w_wdata = {1'b1, r_key, r_val};
        if (r_wipe) begin
            w_we    = 1'b1;
            w_waddr = r_ptr;
            w_wdata = '0;
        end else if (w_hit) begin
            case (r_kind)
                K_INSERT: w_we = 1'b1;
                K_UPDATE: begin
                    w_we    = 1'b1;
                    w_wdata = {1'b1, w_rd_key, r_val};
                end
                default: w_we = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // start the clearing sweep straight out of reset
            r_wipe    <= 1'b1;
            r_scan    <= 1'b0;
            r_ptr     <= '0;
            r_chk_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_chk_vld <= w_issue;
            if (i_cmd.wipe_start) begin
                r_wipe <= 1'b1;
                r_ptr  <= '0;
            end else if (i_cmd.scan_start) begin
                r_scan <= 1'b1;
                r_ptr  <= i_cmd.take_in ? '0 : w_home;
            end else if (r_wipe) begin
                r_ptr <= r_ptr + 1'b1;
                if (w_wipe_last) begin
                    r_wipe <= 1'b0;
                end
            end else if (w_issue) begin
                r_ptr <= n_ptr;
            end
            if (w_finish) begin
                r_scan <= 1'b0;
            end
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_kind <= t_kind'(i_kind);
            r_key  <= i_rec_key;
            r_val  <= i_new_value;
        end
        if (i_cmd.scan_start) begin
            r_cnt <= '0;
        end else if (w_issue) begin
            r_cnt <= r_cnt + 1'b1;
        end
        if (w_issue) begin
            r_chk <= r_ptr;
        end
        if (w_wipe_last) begin
            r_res_st  <= ST_DONE;
            r_res_idx <= '0;
            r_res_fv  <= '0;
        end else if (w_hit) begin
            r_res_idx <= w_idx_ext[IDX_W-1:0];
            if (w_insert) begin
                r_res_st <= (r_chk == w_home) ? ST_DONE : ST_COLLIDE;
                r_res_fv <= '0;
            end else begin
                r_res_st <= ST_FOUND;
                r_res_fv <= w_rd_val;
            end
        end else if (w_miss) begin
            r_res_st  <= w_insert ? ST_FULL : ST_MISSING;
            r_res_idx <= '0;
            r_res_fv  <= '0;
        end
        if (i_cmd.load_out) begin
            r_out_st  <= r_res_st;
            r_out_idx <= r_res_idx;
            r_out_fv  <= r_res_fv;
        end
    end

    assign o_sts.wipe_done = w_wipe_last;
    assign o_sts.hash_done = w_hash_done;
    assign o_sts.scan_done = w_finish;
    assign o_sts.out_free  = !r_out_vld || !i_stall;

    assign o_valid       = r_out_vld;
    assign o_status      = r_out_st;
    assign o_slot_index  = r_out_idx;
    assign o_found_value = r_out_fv;

    a_wipe_scan_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_wipe && r_scan))
        else $error("sweep and probe active together");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(SLOTS) || !r_scan)
        else $error("probe count ran past table size");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_vld || !i_stall))
        else $error("output word overwritten while stalled");

    a_slot_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && !r_wipe) |-> (r_chk_vld && r_scan))
        else $error("slot write without a checked slot");

endmodule

// File: hdl/lpht_ctrl.sv
module lpht_ctrl import lpht_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [KIND_W-1:0] i_kind,
    output logic              o_stall,
    output t_cmd              o_cmd,
    input  t_sts              i_sts
);

    t_state r_state;
    t_state n_state;
    t_kind  w_kind;
    logic   w_take;

    assign w_kind = t_kind'(i_kind);
    assign w_take = (r_state == S_IDLE) && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (i_sts.wipe_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    case (w_kind)
                        K_CLEAR:  n_state = S_WIPE;
                        K_INSERT: n_state = S_HASH;
                        default:  n_state = S_SCAN;
                    endcase
                end
            end
            S_WIPE: begin
                if (i_sts.wipe_done) begin
                    n_state = S_REPLY;
                end
            end
            S_HASH: begin
                if (i_sts.hash_done) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_REPLY;
                end
            end
            S_REPLY: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    always_comb begin
        o_stall          = (r_state != S_IDLE);
        o_cmd.take_in    = w_take;
        o_cmd.wipe_start = w_take && (w_kind == K_CLEAR);
        o_cmd.hash_start = w_take && (w_kind == K_INSERT);
        o_cmd.scan_start = (w_take && (w_kind == K_LOOKUP || w_kind == K_UPDATE))
                        || ((r_state == S_HASH) && i_sts.hash_done);
        o_cmd.load_out   = (r_state == S_REPLY) && i_sts.out_free;
    end

endmodule

// File: hdl/linear_probe_hash_table.sv
// channel  dir  handshake          word
// -------  ---  -----------------  -------------------------------------------
// request  in   i_valid / o_stall  i_kind, i_rec_key, i_new_value
// reply    out  o_valid / i_stall  o_status, o_slot_index, o_found_value
//
// One request at a time; the reply register lets a new request in while a
// reply still waits. Clear writes one slot per cycle; lookup and update read
// one slot per cycle. Insert first takes the key modulo SLOTS (reciprocal
// multiply). After reset a sweep empties every slot; o_stall stays high meanwhile.
// i_stall only holds the reply register; a finished reply waits for it.
module linear_probe_hash_table import lpht_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [KEY_W-1:0]  i_rec_key,
    input  logic [VAL_W-1:0]  i_new_value,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [STAT_W-1:0] o_status,
    output logic [IDX_W-1:0]  o_slot_index,
    output logic [VAL_W-1:0]  o_found_value
);

    t_cmd w_cmd;
    t_sts w_sts;

    lpht_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .o_stall (o_stall),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    lpht_dp #(.SLOTS(SLOTS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_kind        (i_kind),
        .i_rec_key     (i_rec_key),
        .i_new_value   (i_new_value),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_slot_index  (o_slot_index),
        .o_found_value (o_found_value)
    );

endmodule
